// File: design/rttcs_pkg.sv
// ----------------------------------------------------------------------------
// rttcs_pkg: shared definitions for the RTT table centdian score block
// Table geometry, fixed-point constants, action codes and the control struct
// of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package rttcs_pkg;

	// Table geometry.
	localparam int PEER_SLOTS = 64;
	localparam int IDX_W      = $clog2(PEER_SLOTS);
	localparam int CNT_W      = $clog2(PEER_SLOTS + 1);

	// Fixed-point widths.
	localparam int W_W    = 17;
	localparam int VAL_W  = 32;
	localparam int PROD_W = W_W + VAL_W;
	localparam int ACC_W  = 58;
	localparam int SCORE_W = 33;
	localparam logic [W_W-1:0] ONE_Q16 = 17'd65536;

	// Configuration register indexes.
	localparam logic [1:0] REG_SMOOTHING = 2'd0;
	localparam logic [1:0] REG_CENTER    = 2'd1;
	localparam logic [1:0] REG_QUEUE     = 2'd2;

	// Input action codes.
	typedef enum logic [1:0] {
		ACT_UPDATE = 2'd0,
		ACT_CLEAR  = 2'd1,
		ACT_SCORE  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	// Alignment of the product before it is accumulated.
	typedef enum logic [1:0] {
		SH_0  = 2'd0,
		SH_8  = 2'd1,
		SH_16 = 2'd2,
		SH_NA = 2'd3
	} mac_shift_t;

	typedef struct packed {
		logic       en;
		logic       clear;
		mac_shift_t shift;
	} mac_ctl_t;

	// Saturate a Q1.16 weight to one.
	function automatic logic [W_W-1:0] clamp_q16(input logic [W_W-1:0] w);
		return (w > ONE_Q16) ? ONE_Q16 : w;
	endfunction

endpackage

// File: design/rttcs_mac.sv
// ----------------------------------------------------------------------------
// rttcs_mac: shared multiply-accumulate unit
// One 17 x 32 bit multiplier whose product is aligned and added into a
// wide accumulator, one product per cycle under sequencer control.
// ----------------------------------------------------------------------------
module rttcs_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rttcs_pkg::mac_ctl_t               ctl,
	input  logic [rttcs_pkg::W_W-1:0]         op_a,
	input  logic [rttcs_pkg::VAL_W-1:0]       op_b,
	output logic [rttcs_pkg::ACC_W-1:0]       acc
);

	logic [rttcs_pkg::PROD_W-1:0] prod;
	logic [rttcs_pkg::ACC_W-1:0]  prod_al;
	logic [rttcs_pkg::ACC_W-1:0]  acc_q;

	// Multiply and align the product.
	always_comb begin
		prod = rttcs_pkg::PROD_W'(op_a) * rttcs_pkg::PROD_W'(op_b);
		case (ctl.shift)
			rttcs_pkg::SH_0:  prod_al = rttcs_pkg::ACC_W'(prod);
			rttcs_pkg::SH_8:  prod_al = rttcs_pkg::ACC_W'(prod) << 8;
			rttcs_pkg::SH_16: prod_al = rttcs_pkg::ACC_W'(prod) << 16;
			default:          prod_al = '0;
		endcase
	end

	// Accumulate, or start a fresh sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= prod_al;
		end else if (ctl.en) begin
			acc_q <= acc_q + prod_al;
		end
	end

	assign acc = acc_q;

endmodule

// File: design/rtt_table_centdian_score_core.sv
// ----------------------------------------------------------------------------
// rtt_table_centdian_score_core: per-peer RTT table with centdian score
// Smoothed RTT estimates per peer, table clear, and a score built from the
// largest estimate, the median of nonzero estimates and the queue length.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     action, peer_id, rtt_sample,
//                                             queue_length
// out      output     out_valid / out_ready   score, center_value,
//                                             median_value, no_samples
// cfg      input      cfg_we (no wait)        cfg_index, cfg_wdata
//
// An update reads, runs two multiplier passes and writes back. A score
// makes one scan for the count and maximum, then a rank-counting scan per
// candidate through the single read port of the estimate memory, then
// three passes of the shared multiplier. One item is in work at a time;
// in_ready is high in idle even while a finished result waits in the output
// register. Reset empties the table at once through the presence flags. A
// stalled output holds the sequencer in its final state until the result
// register frees.
module rtt_table_centdian_score_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [rttcs_pkg::W_W-1:0]            cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           action,
	input  logic [5:0]                           peer_id,
	input  logic [31:0]                          rtt_sample,
	input  logic [15:0]                          queue_length,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [32:0]                          score,
	output logic [31:0]                          center_value,
	output logic [31:0]                          median_value,
	output logic                                 no_samples
);

	localparam int N  = rttcs_pkg::PEER_SLOTS;
	localparam int IW = rttcs_pkg::IDX_W;
	localparam int CW = rttcs_pkg::CNT_W;

	typedef enum logic [12:0] {
		ST_IDLE     = 13'b0000000000001,
		ST_UPD_RD   = 13'b0000000000010,
		ST_UPD_M1   = 13'b0000000000100,
		ST_UPD_M2   = 13'b0000000001000,
		ST_UPD_WR   = 13'b0000000010000,
		ST_SC_MAX   = 13'b0000000100000,
		ST_CAND_RD  = 13'b0000001000000,
		ST_CAND_CHK = 13'b0000010000000,
		ST_CMP      = 13'b0000100000000,
		ST_MS1      = 13'b0001000000000,
		ST_MS2      = 13'b0010000000000,
		ST_MS3      = 13'b0100000000000,
		ST_DONE     = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [rttcs_pkg::W_W-1:0] alpha_q, lambda_q;
	logic [15:0]               gamma_q;

	// Captured input beat.
	logic [1:0]  act_q;
	logic [5:0]  peer_q;
	logic [31:0] sample_q;
	logic [15:0] queue_q;
	logic        slot_ok_q;

	// Table storage.
	logic [31:0]   mem [N];
	logic [N-1:0]  present_q;
	logic [31:0]   rd_q;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          wr_en;

	// Scan state.
	logic [CW-1:0] j_q, c_q, count_q, lt_q, eq_q;
	logic          pend_q, pres_d_q, hit;
	logic [31:0]   center_q, cand_q, hi_q, lo_q, old_q;
	logic          scan_done;
	logic [CW-1:0] k_hi, k_lo;
	logic          is_even;
	logic [CW:0]   lt_eq;
	logic [32:0]   mid_sum;
	logic [31:0]   median_w;

	// Shared unit.
	rttcs_pkg::mac_ctl_t        mac_ctl;
	logic [rttcs_pkg::W_W-1:0]  mac_a;
	logic [31:0]                mac_b;
	logic [rttcs_pkg::ACC_W-1:0] acc;
	logic [rttcs_pkg::W_W-1:0]  alpha_c, lambda_c;

	// Output register.
	logic        out_valid_q;
	logic [32:0] score_q;
	logic [31:0] center_o_q, median_o_q;
	logic        none_o_q;

	assign alpha_c  = rttcs_pkg::clamp_q16(alpha_q);
	assign lambda_c = rttcs_pkg::clamp_q16(lambda_q);
	assign in_ready = (state_q == ST_IDLE);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= 17'd57344;
			lambda_q <= 17'd32768;
			gamma_q  <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				rttcs_pkg::REG_SMOOTHING: alpha_q  <= cfg_wdata;
				rttcs_pkg::REG_CENTER:    lambda_q <= cfg_wdata;
				rttcs_pkg::REG_QUEUE:     gamma_q  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Scan bookkeeping and median targets.
	assign hit       = pend_q && pres_d_q && (rd_q != 32'd0);
	assign scan_done = (j_q == CW'(N)) && !pend_q;
	assign k_hi      = count_q >> 1;
	assign k_lo      = k_hi - CW'(1);
	assign is_even   = !count_q[0];
	assign lt_eq     = (CW+1)'(lt_q) + (CW+1)'(eq_q);
	assign mid_sum   = {1'b0, hi_q} + {1'b0, lo_q};
	always_comb begin
		if (count_q == '0) begin
			median_w = 32'd0;
		end else if (is_even) begin
			median_w = mid_sum[32:1];
		end else begin
			median_w = hi_q;
		end
	end

	// Memory port and multiplier operand selection.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = j_q[IW-1:0];
		wr_en   = 1'b0;
		mac_ctl = '{en: 1'b0, clear: 1'b0, shift: rttcs_pkg::SH_0};
		mac_a   = '0;
		mac_b   = '0;
		case (state_q)
			ST_UPD_RD: begin
				rd_en   = 1'b1;
				rd_addr = IW'(peer_q);
			end
			ST_UPD_M1: begin
				mac_ctl = '{en: 1'b1, clear: 1'b1, shift: rttcs_pkg::SH_0};
				mac_a   = rttcs_pkg::ONE_Q16 - alpha_c;
				mac_b   = sample_q;
			end
			ST_UPD_M2: begin
				mac_ctl = '{en: present_q[IW'(peer_q)], clear: 1'b0,
					shift: rttcs_pkg::SH_0};
				mac_a   = alpha_c;
				mac_b   = old_q;
			end
			ST_UPD_WR: wr_en = slot_ok_q;
			ST_SC_MAX, ST_CMP: rd_en = (j_q != CW'(N));
			ST_CAND_RD: begin
				rd_en   = 1'b1;
				rd_addr = c_q[IW-1:0];
			end
			ST_MS1: begin
				mac_ctl = '{en: 1'b1, clear: 1'b1, shift: rttcs_pkg::SH_8};
				mac_a   = lambda_c;
				mac_b   = center_q;
			end
			ST_MS2: begin
				mac_ctl = '{en: 1'b1, clear: 1'b0, shift: rttcs_pkg::SH_8};
				mac_a   = rttcs_pkg::ONE_Q16 - lambda_c;
				mac_b   = median_w;
			end
			ST_MS3: begin
				mac_ctl = '{en: 1'b1, clear: 1'b0, shift: rttcs_pkg::SH_16};
				mac_a   = {1'b0, gamma_q};
				mac_b   = {16'd0, queue_q};
			end
			default: ;
		endcase
	end

	rttcs_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (mac_a),
		.op_b   (mac_b),
		.acc    (acc)
	);

	// Estimate memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[IW'(peer_q)] <= acc[47:16];
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Payload registers of the sequencer.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q     <= action;
			peer_q    <= peer_id;
			sample_q  <= rtt_sample;
			queue_q   <= queue_length;
			slot_ok_q <= (32'(peer_id) < N);
		end
		if (state_q == ST_UPD_M1) begin
			old_q <= rd_q;
		end
		if (state_q == ST_CAND_CHK) begin
			cand_q <= rd_q;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			present_q <= '0;
			j_q       <= '0;
			c_q       <= '0;
			count_q   <= '0;
			lt_q      <= '0;
			eq_q      <= '0;
			pend_q    <= 1'b0;
			pres_d_q  <= 1'b0;
			center_q  <= '0;
			hi_q      <= '0;
			lo_q      <= '0;
		end else begin
			pend_q   <= rd_en && (state_q == ST_SC_MAX || state_q == ST_CMP);
			pres_d_q <= present_q[rd_addr];
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						j_q      <= '0;
						c_q      <= '0;
						count_q  <= '0;
						center_q <= '0;
						hi_q     <= '0;
						lo_q     <= '0;
						case (action)
							rttcs_pkg::ACT_UPDATE: state_q <= ST_UPD_RD;
							rttcs_pkg::ACT_CLEAR: begin
								present_q <= '0;
								state_q   <= ST_DONE;
							end
							rttcs_pkg::ACT_SCORE: state_q <= ST_SC_MAX;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_UPD_RD: state_q <= ST_UPD_M1;
				ST_UPD_M1: state_q <= ST_UPD_M2;
				ST_UPD_M2: state_q <= ST_UPD_WR;
				ST_UPD_WR: begin
					if (slot_ok_q) begin
						present_q[IW'(peer_q)] <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				// First scan: count nonzero estimates and find the maximum.
				ST_SC_MAX: begin
					if (rd_en) begin
						j_q <= j_q + CW'(1);
					end
					if (pend_q && pres_d_q && rd_q > center_q) begin
						center_q <= rd_q;
					end
					if (hit) begin
						count_q <= count_q + CW'(1);
					end
					if (scan_done) begin
						state_q <= (count_q == '0) ? ST_MS1 : ST_CAND_RD;
					end
				end
				ST_CAND_RD: state_q <= ST_CAND_CHK;
				// Only present nonzero candidates get a rank scan.
				ST_CAND_CHK: begin
					if (pres_d_q && rd_q != 32'd0) begin
						j_q     <= '0;
						lt_q    <= '0;
						eq_q    <= '0;
						state_q <= ST_CMP;
					end else begin
						c_q     <= c_q + CW'(1);
						state_q <= (c_q == CW'(N - 1)) ? ST_MS1 : ST_CAND_RD;
					end
				end
				// Rank scan: count smaller and equal values for the candidate.
				ST_CMP: begin
					if (rd_en) begin
						j_q <= j_q + CW'(1);
					end
					if (hit && rd_q < cand_q) begin
						lt_q <= lt_q + CW'(1);
					end
					if (hit && rd_q == cand_q) begin
						eq_q <= eq_q + CW'(1);
					end
					if (scan_done) begin
						if (lt_q <= k_hi && (CW+1)'(k_hi) < lt_eq) begin
							hi_q <= cand_q;
						end
						if (is_even && lt_q <= k_lo && (CW+1)'(k_lo) < lt_eq) begin
							lo_q <= cand_q;
						end
						c_q     <= c_q + CW'(1);
						state_q <= (c_q == CW'(N - 1)) ? ST_MS1 : ST_CAND_RD;
					end
				end
				ST_MS1: state_q <= ST_MS2;
				ST_MS2: state_q <= ST_MS3;
				ST_MS3: state_q <= ST_DONE;
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: loaded when the result beat is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			if (act_q == rttcs_pkg::ACT_SCORE) begin
				score_q    <= acc[56:24];
				center_o_q <= center_q;
				median_o_q <= median_w;
				none_o_q   <= (count_q == '0);
			end else begin
				score_q    <= '0;
				center_o_q <= '0;
				median_o_q <= '0;
				none_o_q   <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign score        = score_q;
	assign center_value = center_o_q;
	assign median_value = median_o_q;
	assign no_samples   = none_o_q;

endmodule

// File: design/rttcs_checker.sv
// ----------------------------------------------------------------------------
// rttcs_checker: port-level checks for the RTT table centdian score block
// Watches the result channel and checks holding and value relations.
// ----------------------------------------------------------------------------
module rttcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [32:0] score,
	input logic [31:0] center_value,
	input logic [31:0] median_value,
	input logic        no_samples
);

	// A stalled result beat stays and holds its score.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(score))
		else $error("stalled result beat changed");

	// No nonzero estimate means a zero median.
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_samples |-> median_value == 32'd0)
		else $error("median nonzero without samples");

	// The median never exceeds the maximum.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> median_value <= center_value)
		else $error("median above centre");

endmodule

bind rtt_table_centdian_score_core rttcs_checker u_rttcs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.score        (score),
	.center_value (center_value),
	.median_value (median_value),
	.no_samples   (no_samples)
);
